### design/sync_length_frame_deframer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length frame deframer
// Clocked property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define SLFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be true at a clock edge outside reset
`define SLFD_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define SLFD_ASSERT(label, clk, rst_n, prop, msg)

`define SLFD_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### design/slfd_pkg.sv
// ----------------------------------------------------------------------------
// slfd_pkg
// Shared constants and the result record of the sync/length frame deframer.
// ----------------------------------------------------------------------------
package slfd_pkg;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] IDX_SYNC_WORD    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] IDX_WIRE_VERSION = 1'b1;

    // Frame layout
    localparam int unsigned FRAME_BASE    = 14;  // header plus CRC bytes
    localparam int unsigned PAYLOAD_START = 12;  // first payload byte position

    // Saturating byte position
    localparam int unsigned         POS_W   = 17;
    localparam logic [POS_W-1:0]    POS_MAX = '1;

    // Output stream packing
    localparam int unsigned TDATA_W = 104;

    // One result as produced by the parser
    typedef struct packed {
        logic        valid;
        logic        kind;          // 0 payload byte, 1 frame summary
        logic [7:0]  payload_byte;
        logic [7:0]  flags_field;
        logic [15:0] board_field;
        logic [15:0] sequence_field;
        logic [15:0] command_field;
        logic [15:0] length_field;
        logic [15:0] crc_value;
        logic        frame_ok;
    } t_result;

endpackage

### design/sync_length_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_core
// Byte-stream deframer: checks sync and version, passes payload bytes and
// reports one summary per frame on the output stream.
//
//  Channel   Direction  Content
//  s_axis    in         tdata = data_byte, tlast = end_of_frame
//  m_axis    out        tdata = result fields, tuser = kind
//  cfg       in         we / addr / wdata: sync_word (0), wire_version (1)
//
//  One byte per clock unless the output stalls; each result is registered
//  at its byte's transfer, through the parser decode and one result register.
//  The input is ready whenever the result register is empty or being taken,
//  so a stalled output holds at most one result and back-pressures the input.
//  Reset is synchronous, active low, and clears frame state, config and tvalid.
// ----------------------------------------------------------------------------
`include "sync_length_frame_deframer_core_assert.svh"

module sync_length_frame_deframer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input byte stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [7:0] data_byte
    input  logic                              i_s_axis_tlast,  // end_of_frame
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] payload_byte, [15:8] flags_field, [31:16] board_field,
    // [47:32] sequence_field, [63:48] command_field, [79:64] length_field,
    // [95:80] crc_value, [96] frame_ok, [103:97] zero
    output logic [slfd_pkg::TDATA_W-1:0]      o_m_axis_tdata,
    output logic                              o_m_axis_tuser,  // [0] kind
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [slfd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [slfd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic [15:0]        r_sync_word;
    logic [7:0]         r_wire_version;
    logic               r_out_valid;
    slfd_pkg::t_result  r_out;
    slfd_pkg::t_result  res;
    logic               in_xfer;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word    <= '0;
            r_wire_version <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                slfd_pkg::IDX_SYNC_WORD:    r_sync_word    <= i_cfg_wdata[15:0];
                slfd_pkg::IDX_WIRE_VERSION: r_wire_version <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    slfd_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (in_xfer),
        .i_byte         (i_s_axis_tdata),
        .i_eof          (i_s_axis_tlast),
        .i_sync_word    (r_sync_word),
        .i_wire_version (r_wire_version),
        .o_res          (res)
    );

    // Result register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= res.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge i_clk) begin
        if (in_xfer && res.valid) begin
            r_out <= res;
        end
    end

    // Output stream packing
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {7'b0, r_out.frame_ok, r_out.crc_value,
                              r_out.length_field, r_out.command_field,
                              r_out.sequence_field, r_out.board_field,
                              r_out.flags_field, r_out.payload_byte};

    // Checks
    `SLFD_ASSERT(a_payload_fields_clear, i_clk, i_rst_n,
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[103:8] == '0),
        "payload transfer carries summary fields")
    `SLFD_ASSERT(a_summary_byte_clear, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[7:0] == 8'h00),
        "summary transfer carries a payload byte")
    `SLFD_NEVER(a_no_lost_result, i_clk, i_rst_n,
        in_xfer && r_out_valid && !i_m_axis_tready,
        "input taken while a stalled result is held")

endmodule

### design/slfd_parse.sv
// ----------------------------------------------------------------------------
// slfd_parse
// Frame state and per-byte decode: header capture, payload pass, summary.
// ----------------------------------------------------------------------------
`include "sync_length_frame_deframer_core_assert.svh"

module slfd_parse (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,      // byte transfer taken this cycle
    input  logic [7:0]             i_byte,
    input  logic                   i_eof,
    input  logic [15:0]            i_sync_word,
    input  logic [7:0]             i_wire_version,
    output slfd_pkg::t_result      o_res
);

    // Header byte positions
    localparam logic [slfd_pkg::POS_W-1:0] POS_SYNC_HI = 17'd0;
    localparam logic [slfd_pkg::POS_W-1:0] POS_SYNC_LO = 17'd1;
    localparam logic [slfd_pkg::POS_W-1:0] POS_VERSION = 17'd2;
    localparam logic [slfd_pkg::POS_W-1:0] POS_FLAGS   = 17'd3;
    localparam logic [slfd_pkg::POS_W-1:0] POS_BOARD_H = 17'd4;
    localparam logic [slfd_pkg::POS_W-1:0] POS_BOARD_L = 17'd5;
    localparam logic [slfd_pkg::POS_W-1:0] POS_SEQ_H   = 17'd6;
    localparam logic [slfd_pkg::POS_W-1:0] POS_SEQ_L   = 17'd7;
    localparam logic [slfd_pkg::POS_W-1:0] POS_CMD_H   = 17'd8;
    localparam logic [slfd_pkg::POS_W-1:0] POS_CMD_L   = 17'd9;
    localparam logic [slfd_pkg::POS_W-1:0] POS_LEN_H   = 17'd10;
    localparam logic [slfd_pkg::POS_W-1:0] POS_LEN_L   = 17'd11;

    logic [slfd_pkg::POS_W-1:0] r_pos,   n_pos;
    logic [7:0]                 r_sync_high, n_sync_high;
    logic [7:0]                 r_flags, n_flags;
    logic [15:0]                r_board, n_board;
    logic [15:0]                r_seq,   n_seq;
    logic [15:0]                r_cmd,   n_cmd;
    logic [15:0]                r_len,   n_len;
    logic [15:0]                r_crc,   n_crc;
    logic                       r_bad,   n_bad;

    logic [slfd_pkg::POS_W-1:0] rel;
    logic [slfd_pkg::POS_W-1:0] len_ext;
    logic [slfd_pkg::POS_W:0]   count;
    logic                       emit;
    logic                       ok;

    // Next frame state for the byte at the input
    always_comb begin
        n_pos       = (r_pos == slfd_pkg::POS_MAX) ? slfd_pkg::POS_MAX
                                                   : r_pos + 17'd1;
        n_sync_high = r_sync_high;
        n_flags     = r_flags;
        n_board     = r_board;
        n_seq       = r_seq;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_crc       = r_crc;
        n_bad       = r_bad;
        emit        = 1'b0;
        rel         = r_pos - slfd_pkg::POS_W'(slfd_pkg::PAYLOAD_START);
        len_ext     = {1'b0, r_len};

        case (r_pos)
            POS_SYNC_HI: n_sync_high = i_byte;
            POS_SYNC_LO: begin
                if ({r_sync_high, i_byte} != i_sync_word) n_bad = 1'b1;
            end
            POS_VERSION: begin
                if (i_byte != i_wire_version) n_bad = 1'b1;
            end
            POS_FLAGS:   n_flags = i_byte;
            POS_BOARD_H: n_board = {i_byte, 8'h00};
            POS_BOARD_L: n_board = {r_board[15:8], i_byte};
            POS_SEQ_H:   n_seq   = {i_byte, 8'h00};
            POS_SEQ_L:   n_seq   = {r_seq[15:8], i_byte};
            POS_CMD_H:   n_cmd   = {i_byte, 8'h00};
            POS_CMD_L:   n_cmd   = {r_cmd[15:8], i_byte};
            POS_LEN_H:   n_len   = {i_byte, 8'h00};
            POS_LEN_L:   n_len   = {r_len[15:8], i_byte};
            default: begin
                // payload, then the two CRC bytes, then ignored trailing bytes
                if (rel < len_ext) begin
                    emit = !r_bad;
                end else if (rel == len_ext) begin
                    n_crc = {i_byte, 8'h00};
                end else if (rel == len_ext + 17'd1) begin
                    n_crc = {r_crc[15:8], i_byte};
                end
            end
        endcase

        count = {1'b0, r_pos} + 18'd1;
        ok    = !n_bad &&
                (count == 18'(slfd_pkg::FRAME_BASE) + {2'b00, n_len});
    end

    // Result record: summary on the marked byte, else a payload byte
    always_comb begin
        o_res              = '0;
        o_res.valid        = i_eof || emit;
        o_res.kind         = i_eof;
        if (i_eof) begin
            o_res.flags_field    = n_flags;
            o_res.board_field    = n_board;
            o_res.sequence_field = n_seq;
            o_res.command_field  = n_cmd;
            o_res.length_field   = n_len;
            o_res.crc_value      = n_crc;
            o_res.frame_ok       = ok;
        end else begin
            o_res.payload_byte   = emit ? i_byte : 8'h00;
        end
    end

    // Frame state: cleared at reset and after each summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sync_high <= '0;
            r_flags     <= '0;
            r_board     <= '0;
            r_seq       <= '0;
            r_cmd       <= '0;
            r_len       <= '0;
            r_crc       <= '0;
            r_bad       <= 1'b0;
        end else if (i_advance) begin
            if (i_eof) begin
                r_pos       <= '0;
                r_sync_high <= '0;
                r_flags     <= '0;
                r_board     <= '0;
                r_seq       <= '0;
                r_cmd       <= '0;
                r_len       <= '0;
                r_crc       <= '0;
                r_bad       <= 1'b0;
            end else begin
                r_pos       <= n_pos;
                r_sync_high <= n_sync_high;
                r_flags     <= n_flags;
                r_board     <= n_board;
                r_seq       <= n_seq;
                r_cmd       <= n_cmd;
                r_len       <= n_len;
                r_crc       <= n_crc;
                r_bad       <= n_bad;
            end
        end
    end

    // Checks
    `SLFD_ASSERT(a_eof_restarts, i_clk, i_rst_n,
        (i_advance && i_eof) |=> (r_pos == '0 && !r_bad),
        "frame state not cleared after end of frame")
    `SLFD_ASSERT(a_bad_only_in_sync, i_clk, i_rst_n,
        $rose(r_bad) |-> ($past(r_pos) == POS_SYNC_LO || $past(r_pos) == POS_VERSION),
        "error flag set outside the sync and version bytes")
    `SLFD_ASSERT(a_ok_needs_header, i_clk, i_rst_n,
        o_res.frame_ok |-> (!r_bad && r_pos >= 17'd13),
        "frame reported good without a clean full header")

endmodule
